// File: design/qrs_pkg.sv
// Shared types and constants of the quadratic root solver.
// Used by every module of the block; depends on nothing.
package qrs_pkg;

	localparam int COEF_W   = 32;
	localparam int DISC_W   = 66;
	localparam int SQ_STEPS = 34;
	localparam int ROOT_W   = 34;
	localparam int SREM_W   = 36;
	localparam int NUM_W    = 35;
	localparam int QBITS    = 33;
	localparam int DEN_W    = 33;

	typedef enum logic [1:0] {
		STAT_REAL    = 2'd0,
		STAT_NEGDISC = 2'd1,
		STAT_AZERO   = 2'd2
	} status_t;

	typedef struct packed {
		status_t                   status;
		logic signed [COEF_W-1:0]  a;
		logic signed [COEF_W-1:0]  b;
	} side_t;

endpackage

// File: design/qrs_front.sv
// Front end: two products and the full-width discriminant, three stages.
// Depends on qrs_pkg.
module qrs_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic signed [qrs_pkg::COEF_W-1:0]     a,
	input  logic signed [qrs_pkg::COEF_W-1:0]     b,
	input  logic signed [qrs_pkg::COEF_W-1:0]     c,
	output logic                                  out_valid,
	output logic [qrs_pkg::DISC_W-1:0]            disc,
	output qrs_pkg::side_t                        side
);
	logic                              v_s1, v_s2, v_s3;
	logic signed [qrs_pkg::COEF_W-1:0] a_s1, b_s1, c_s1, a_s2, b_s2;
	logic [31:0]                       bm;
	logic [63:0]                       bb_s2;
	logic signed [63:0]                p_s2;
	logic [63:0]                       pm;
	logic [qrs_pkg::DISC_W-1:0]        p4, bbx, d_next;
	qrs_pkg::status_t                  st_next;
	logic [qrs_pkg::DISC_W-1:0]        disc_s3;
	qrs_pkg::side_t                    side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign bm = b_s1[31] ? 32'(-b_s1) : 32'(b_s1);

	always_comb begin
		pm  = p_s2[63] ? 64'(-p_s2) : 64'(p_s2);
		p4  = {pm, 2'b00};
		bbx = {2'b00, bb_s2};
		st_next = qrs_pkg::STAT_REAL;
		if (a_s2 == '0) begin
			st_next = qrs_pkg::STAT_AZERO;
			d_next  = '0;
		end else if (p_s2[63] || p_s2 == '0) begin
			d_next = bbx + p4;
		end else if (p4 > bbx) begin
			st_next = qrs_pkg::STAT_NEGDISC;
			d_next  = '0;
		end else begin
			d_next = bbx - p4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1    <= a;
			b_s1    <= b;
			c_s1    <= c;
			a_s2    <= a_s1;
			b_s2    <= b_s1;
			bb_s2   <= 64'(bm) * 64'(bm);
			p_s2    <= 64'(a_s1) * 64'(c_s1);
			disc_s3 <= d_next;
			side_s3 <= '{status: st_next, a: a_s2, b: b_s2};
		end
	end

	assign out_valid = v_s3;
	assign disc      = disc_s3;
	assign side      = side_s3;
endmodule

// File: design/qrs_sqrt.sv
// Pipelined integer square root, one stage per two bits of the radicand.
// Depends on qrs_pkg.
module qrs_sqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           en,
	input  logic                           in_valid,
	input  logic [qrs_pkg::DISC_W-1:0]     disc,
	input  qrs_pkg::side_t                 in_side,
	output logic                           out_valid,
	output logic [qrs_pkg::ROOT_W-1:0]     root,
	output qrs_pkg::side_t                 out_side
);
	localparam int N = qrs_pkg::SQ_STEPS;

	logic                          v_s    [0:N];
	logic [2*N-1:0]                d_s    [0:N];
	logic [qrs_pkg::ROOT_W-1:0]    root_s [0:N];
	logic [qrs_pkg::SREM_W-1:0]    rem_s  [0:N];
	qrs_pkg::side_t                side_s [0:N];

	// The radicand is zero-extended to an even number of bits, one pair per stage.
	assign v_s[0]    = in_valid;
	assign d_s[0]    = (2*N)'(disc);
	assign root_s[0] = '0;
	assign rem_s[0]  = '0;
	assign side_s[0] = in_side;

	for (genvar k = 0; k < N; k++) begin : g_stage
		localparam int POS = 2 * (N - 1 - k);
		logic [qrs_pkg::SREM_W:0]   cur;
		logic [qrs_pkg::SREM_W:0]   trial;
		logic                       ge;

		assign cur   = {rem_s[k][qrs_pkg::SREM_W-2:0], d_s[k][POS+1:POS]};
		assign trial = {1'b0, root_s[k], 2'b01};
		assign ge    = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[k+1]    <= d_s[k];
				side_s[k+1] <= side_s[k];
				rem_s[k+1]  <= ge ? qrs_pkg::SREM_W'(cur - trial) : qrs_pkg::SREM_W'(cur);
				root_s[k+1] <= {root_s[k][qrs_pkg::ROOT_W-2:0], ge};
			end
		end
	end

	assign out_valid = v_s[N];
	assign root      = root_s[N];
	assign out_side  = side_s[N];
endmodule

// File: design/qrs_div.sv
// Two-lane pipelined restoring divider with saturation to 32 bits.
// Depends on qrs_pkg.
module qrs_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  logic signed [qrs_pkg::NUM_W-1:0]      num [2],
	input  logic signed [qrs_pkg::COEF_W-1:0]     a,
	input  qrs_pkg::status_t                      in_status,
	output logic                                  out_valid,
	output logic [31:0]                           quot [2],
	output logic [1:0]                            sat,
	output qrs_pkg::status_t                      out_status
);
	localparam int NW = qrs_pkg::NUM_W - 1 + FRAC_BITS;
	localparam int QB = qrs_pkg::QBITS;
	localparam int DW = qrs_pkg::DEN_W;

	logic             v_s  [0:QB+2];
	qrs_pkg::status_t st_s [0:QB+2];
	logic [DW-1:0]    den_s [0:QB];
	logic [DW-1:0]    den0;
	logic [31:0]      am;

	assign am   = a[31] ? 32'(-a) : 32'(a);
	assign den0 = {am, 1'b0};

	// Valid and status ride along the entry stage, the quotient steps and the
	// saturating output register.
	for (genvar s = 0; s <= QB + 1; s++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[s+1] <= 1'b0;
			end else if (en) begin
				v_s[s+1] <= (s == 0) ? in_valid : v_s[s];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				st_s[s+1] <= (s == 0) ? in_status : st_s[s];
			end
		end
	end
	assign v_s[0]  = in_valid;
	assign st_s[0] = in_status;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0] <= den0;
		end
	end
	for (genvar s = 1; s <= QB; s++) begin : g_den
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[s] <= den_s[s-1];
			end
		end
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		logic [QB-1:0]  bits_s [0:QB];
		logic [DW-1:0]  rem_s  [0:QB];
		logic [QB-1:0]  q_s    [0:QB];
		logic           neg_s  [0:QB];
		logic           ovf_s  [0:QB];
		logic [qrs_pkg::NUM_W-2:0] nm;
		logic [NW-1:0]  dvd;
		logic           ovf0;
		logic           sat_n;
		logic [31:0]    res_n;

		assign nm   = num[l][qrs_pkg::NUM_W-1] ? (qrs_pkg::NUM_W-1)'(-num[l])
		                                       : (qrs_pkg::NUM_W-1)'(num[l]);
		assign dvd  = NW'(nm) << FRAC_BITS;
		assign ovf0 = 66'(dvd) >= {den0, 33'b0};

		always_ff @(posedge clk) begin
			if (en) begin
				bits_s[0] <= dvd[QB-1:0];
				rem_s[0]  <= DW'(dvd >> QB);
				q_s[0]    <= '0;
				neg_s[0]  <= num[l][qrs_pkg::NUM_W-1] ^ a[31];
				ovf_s[0]  <= ovf0;
			end
		end

		for (genvar s = 0; s < QB; s++) begin : g_step
			logic [DW:0] t;
			logic        ge;
			assign t  = {rem_s[s], bits_s[s][QB-1-s]};
			assign ge = t >= {1'b0, den_s[s]};
			always_ff @(posedge clk) begin
				if (en) begin
					bits_s[s+1] <= bits_s[s];
					rem_s[s+1]  <= ge ? DW'(t - {1'b0, den_s[s]}) : DW'(t);
					q_s[s+1]    <= {q_s[s][QB-2:0], ge};
					neg_s[s+1]  <= neg_s[s];
					ovf_s[s+1]  <= ovf_s[s];
				end
			end
		end

		always_comb begin
			sat_n = 1'b0;
			if (neg_s[QB]) begin
				if (ovf_s[QB] || q_s[QB] > 33'h0_8000_0000) begin
					sat_n = 1'b1;
					res_n = 32'h8000_0000;
				end else begin
					res_n = 32'(-q_s[QB]);
				end
			end else if (ovf_s[QB] || q_s[QB] > 33'h0_7FFF_FFFF) begin
				sat_n = 1'b1;
				res_n = 32'h7FFF_FFFF;
			end else begin
				res_n = q_s[QB][31:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quot[l] <= res_n;
				sat[l]  <= sat_n;
			end
		end
	end

	assign out_valid  = v_s[QB+2];
	assign out_status = st_s[QB+2];
endmodule

// File: design/quadratic_root_solver_unit.sv
// Top level of the quadratic root solver: stream ports and root assembly.
// Depends on qrs_pkg, qrs_front, qrs_sqrt and qrs_div.
//
// One transaction on the slave side carries the coefficients a, b and c of
// a*x^2 + b*x + c = 0 in signed fixed point with FRAC_BITS fraction bits.
// One transaction on the master side returns both roots, a status code
// (real roots, negative discriminant, or a equal to zero) and a flag that
// is set when either root was clamped to the signed 32-bit range.
// The datapath is one pipeline: three front stages form b*b and a*c and
// the exact discriminant, 34 stages take its square root two bits at a
// time, one stage forms -b +/- sqrt, 35 stages run two restoring dividers
// side by side, and one output register assembles the result.
// Throughput is one equation per cycle while m_tready does not stall the
// output, set by the one-stage-per-step square root and divider pipelines.
// Reset clears all valid bits; no output transaction is pending after it.
// When the receiver holds m_tready low with a result waiting, the whole
// pipeline, bubbles included, freezes and s_tready drops; every stage
// holds its contents, so nothing is lost or repeated.
module quadratic_root_solver_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,  // coef_a[31:0], coef_b[63:32], coef_c[95:64]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // root_plus[31:0], root_minus[63:32]
	output logic [2:0]  m_tuser   // status[1:0], saturated[2]
);
	// Global advance: the pipeline moves whenever the output slot is free.
	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	logic                               fr_valid;
	logic [qrs_pkg::DISC_W-1:0]         fr_disc;
	qrs_pkg::side_t                     fr_side;

	qrs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.a         (s_tdata[31:0]),
		.b         (s_tdata[63:32]),
		.c         (s_tdata[95:64]),
		.out_valid (fr_valid),
		.disc      (fr_disc),
		.side      (fr_side)
	);

	logic                               sq_valid;
	logic [qrs_pkg::ROOT_W-1:0]         sq_root;
	qrs_pkg::side_t                     sq_side;

	qrs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.disc      (fr_disc),
		.in_side   (fr_side),
		.out_valid (sq_valid),
		.root      (sq_root),
		.out_side  (sq_side)
	);

	// Numerators -b + S and -b - S, both in 35-bit two's complement.
	logic                               nv_s;
	logic signed [qrs_pkg::NUM_W-1:0]   num_s [2];
	logic signed [qrs_pkg::COEF_W-1:0]  a_s;
	qrs_pkg::status_t                   st_s;
	logic signed [qrs_pkg::NUM_W-1:0]   nb, sx;

	assign nb = -qrs_pkg::NUM_W'(sq_side.b);
	assign sx = qrs_pkg::NUM_W'(sq_root);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nv_s <= 1'b0;
		end else if (en) begin
			nv_s <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0] <= nb + sx;
			num_s[1] <= nb - sx;
			a_s      <= sq_side.a;
			st_s     <= sq_side.status;
		end
	end

	logic                               dv_valid;
	logic [31:0]                        dv_quot [2];
	logic [1:0]                         dv_sat;
	qrs_pkg::status_t                   dv_status;

	qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (nv_s),
		.num        (num_s),
		.a          (a_s),
		.in_status  (st_s),
		.out_valid  (dv_valid),
		.quot       (dv_quot),
		.sat        (dv_sat),
		.out_status (dv_status)
	);

	// Output register: a special case forces zero roots and a clear flag.
	logic        out_v_q;
	logic [63:0] out_data_q;
	logic [2:0]  out_user_q;
	logic        real_c;

	assign real_c = dv_status == qrs_pkg::STAT_REAL;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q <= real_c ? {dv_quot[1], dv_quot[0]} : 64'd0;
			out_user_q <= {real_c && (dv_sat != 2'b00), dv_status};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

	// A special case never carries roots.
	a_zero_roots: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1:0] != qrs_pkg::STAT_REAL |-> m_tdata == 64'd0)
		else $error("special case returned nonzero roots");

	// The status code never takes the unused value.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser[1:0] != 2'b11)
		else $error("unused status code");

	// Saturation can only be flagged on real roots.
	a_sat_real: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[2] |-> m_tuser[1:0] == qrs_pkg::STAT_REAL)
		else $error("saturation flagged without real roots");

	// Input is taken exactly when the pipeline advances.
	a_ready_adv: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready out of step with the pipeline");
endmodule
